// ===== rtl/core/wds_pkg.sv =====
// Shared types and fixed widths for the Welford duration statistics block.
// No dependencies; imported by wds_div, wds_sqrt and welford_duration_statistics.
package wds_pkg;

	localparam int OUT_WIDTH   = 32;
	localparam int M2_WIDTH    = 64;
	localparam int ROOT_WIDTH  = 32;
	localparam int DIV_STEP_W  = $clog2(M2_WIDTH + 1);
	localparam int SQRT_STEP_W = $clog2(ROOT_WIDTH + 1);

	typedef struct packed {
		logic start;
		logic full;
	} div_ctl_t;

endpackage

// ===== rtl/core/welford_duration_statistics.sv =====
// Welford duration statistics: sequencer, state registers and output register.
// First item: no divide; the sequencer goes straight to its output step. Later items
// pass the serial mean divide (DW steps, DW = min(DURATION_WIDTH, 32)), the
// 64-step variance divide and the 32-step square root; in_ready returns with the result.
// Async active-low reset clears count, mean, M2, min, max and all control state.
// Depends on wds_pkg, wds_div and wds_sqrt.
module welford_duration_statistics #(
	parameter int DURATION_WIDTH = 32,
	parameter int COUNT_WIDTH    = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [wds_pkg::OUT_WIDTH-1:0]     duration,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [wds_pkg::OUT_WIDTH-1:0]     sample_count,
	output logic [wds_pkg::OUT_WIDTH-1:0]     mean_value,
	output logic                              mean_valid,
	output logic [wds_pkg::OUT_WIDTH-1:0]     std_dev,
	output logic                              std_dev_valid,
	output logic [wds_pkg::OUT_WIDTH-1:0]     min_value,
	output logic [wds_pkg::OUT_WIDTH-1:0]     max_value
);
	import wds_pkg::*;

	localparam int DW = (DURATION_WIDTH > OUT_WIDTH) ? OUT_WIDTH : DURATION_WIDTH;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV1   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_ACC    = 3'd3;
	localparam logic [2:0] ST_VSTART = 3'd4;
	localparam logic [2:0] ST_DIV2   = 3'd5;
	localparam logic [2:0] ST_SQRT   = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0]             state_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [DW-1:0]          mean_q;
	logic [M2_WIDTH-1:0]    m2_q;
	logic [DW-1:0]          min_q;
	logic [DW-1:0]          max_q;
	logic [DW-1:0]          mag_q;
	logic [DW-1:0]          mag2_q;
	logic                   up_q;
	logic [M2_WIDTH-1:0]    prod_q;
	logic [ROOT_WIDTH-1:0]  std_q;
	logic                   out_valid_q;

	logic [OUT_WIDTH-1:0]   sample_count_q;
	logic [OUT_WIDTH-1:0]   mean_value_q;
	logic                   mean_valid_q;
	logic [OUT_WIDTH-1:0]   std_dev_q;
	logic                   std_dev_valid_q;
	logic [OUT_WIDTH-1:0]   min_value_q;
	logic [OUT_WIDTH-1:0]   max_value_q;

	logic                   accept;
	logic [DW-1:0]          d_in;
	logic                   d_ge;
	logic [DW-1:0]          mag_in;
	logic [COUNT_WIDTH-1:0] count_next;
	div_ctl_t               div_ctl;
	logic [M2_WIDTH-1:0]    div_dividend;
	logic [COUNT_WIDTH-1:0] div_divisor;
	logic                   div_done;
	logic [M2_WIDTH-1:0]    div_quot;
	logic [DW-1:0]          quot_short;
	logic                   sqrt_start;
	logic                   sqrt_done;
	logic [ROOT_WIDTH-1:0]  sqrt_root;
	logic [M2_WIDTH-1:0]    prod_w;
	logic [M2_WIDTH:0]      m2_sum;
	logic                   out_load;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign d_in       = duration[DW-1:0];
	assign d_ge       = d_in >= mean_q;
	assign mag_in     = d_ge ? (d_in - mean_q) : (mean_q - d_in);
	assign count_next = (count_q == '1) ? count_q : count_q + 1'b1;
	assign quot_short = div_quot[DW-1:0];
	assign prod_w     = M2_WIDTH'(mag_q) * M2_WIDTH'(mag2_q);
	assign m2_sum     = {1'b0, m2_q} + {1'b0, prod_q};
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.full  = 1'b0;
		div_dividend  = M2_WIDTH'(mag_in) << (M2_WIDTH - DW);
		div_divisor   = count_next;
		if (accept && count_q != '0) begin
			div_ctl.start = 1'b1;
		end else if (state_q == ST_VSTART) begin
			div_ctl.start = 1'b1;
			div_ctl.full  = 1'b1;
			div_dividend  = m2_q;
			div_divisor   = count_q - 1'b1;
		end
	end

	assign sqrt_start = (state_q == ST_DIV2) && div_done;

	wds_div #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.SHORT_STEPS (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	wds_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quot),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			mean_q      <= '0;
			m2_q        <= '0;
			min_q       <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= count_next;
						if (count_q == '0) begin
							mean_q  <= d_in;
							m2_q    <= '0;
							min_q   <= d_in;
							max_q   <= d_in;
							state_q <= ST_DONE;
						end else begin
							if (d_in < min_q) begin
								min_q <= d_in;
							end
							if (d_in > max_q) begin
								max_q <= d_in;
							end
							state_q <= ST_DIV1;
						end
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						mean_q  <= up_q ? (mean_q + quot_short) : (mean_q - quot_short);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					m2_q    <= m2_sum[M2_WIDTH] ? '1 : m2_sum[M2_WIDTH-1:0];
					state_q <= ST_VSTART;
				end
				ST_VSTART: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
			up_q  <= d_ge;
			std_q <= '0;
		end
		if (state_q == ST_DIV1 && div_done) begin
			mag2_q <= mag_q - quot_short;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_w;
		end
		if (state_q == ST_SQRT && sqrt_done) begin
			std_q <= sqrt_root;
		end
		if (out_load) begin
			sample_count_q  <= OUT_WIDTH'(count_q);
			mean_value_q    <= OUT_WIDTH'(mean_q);
			mean_valid_q    <= (count_q != '0);
			std_dev_q       <= std_q;
			std_dev_valid_q <= (count_q > COUNT_WIDTH'(1));
			min_value_q     <= OUT_WIDTH'(min_q);
			max_value_q     <= OUT_WIDTH'(max_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign sample_count  = sample_count_q;
	assign mean_value    = mean_value_q;
	assign mean_valid    = mean_valid_q;
	assign std_dev       = std_dev_q;
	assign std_dev_valid = std_dev_valid_q;
	assign min_value     = min_value_q;
	assign max_value     = max_value_q;

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (min_q <= max_q))
		else $error("min above max");

	a_mean_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q != '0) |-> (mean_q >= min_q && mean_q <= max_q))
		else $error("mean outside min/max");

	a_count_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q != '0 && count_q >= $past(count_q)))
		else $error("count did not advance or saturate");

	a_div_start_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> (state_q == ST_IDLE || state_q == ST_VSTART))
		else $error("divider started outside idle or variance step");

	a_sqrt_done_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == ST_SQRT))
		else $error("square root finished outside its step");

endmodule

// ===== rtl/core/wds_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Short mode runs SHORT_STEPS steps on a left-aligned dividend; full mode runs 64.
// Depends on wds_pkg.
module wds_div #(
	parameter int COUNT_WIDTH = 32,
	parameter int SHORT_STEPS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wds_pkg::div_ctl_t               ctl,
	input  logic [wds_pkg::M2_WIDTH-1:0]    dividend,
	input  logic [COUNT_WIDTH-1:0]          divisor,
	output logic                            done,
	output logic [wds_pkg::M2_WIDTH-1:0]    quotient
);
	import wds_pkg::*;

	logic [M2_WIDTH-1:0]    acc_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [COUNT_WIDTH-1:0] dsr_q;
	logic [DIV_STEP_W-1:0]  step_q;
	logic                   run_q;
	logic                   done_q;
	logic [COUNT_WIDTH:0]   rem_sh;
	logic [COUNT_WIDTH:0]   rem_sub;
	logic                   ge;

	assign rem_sh  = {rem_q, acc_q[M2_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign ge      = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q  <= 1'b1;
				step_q <= ctl.full ? DIV_STEP_W'(M2_WIDTH) : DIV_STEP_W'(SHORT_STEPS);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == DIV_STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			acc_q <= {acc_q[M2_WIDTH-2:0], ge};
			rem_q <= ge ? rem_sub[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

// ===== rtl/core/wds_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Returns floor(sqrt(radicand)) for a 64-bit radicand. Depends on wds_pkg.
module wds_sqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [wds_pkg::M2_WIDTH-1:0]     radicand,
	output logic                             done,
	output logic [wds_pkg::ROOT_WIDTH-1:0]   root
);
	import wds_pkg::*;

	localparam int REM_W = ROOT_WIDTH + 3;

	logic [M2_WIDTH-1:0]    rad_q;
	logic [REM_W-1:0]       rem_q;
	logic [ROOT_WIDTH-1:0]  root_q;
	logic [SQRT_STEP_W-1:0] step_q;
	logic                   run_q;
	logic                   done_q;
	logic [REM_W-1:0]       rem_sh;
	logic [REM_W-1:0]       trial;
	logic                   ge;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[M2_WIDTH-1:M2_WIDTH-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= SQRT_STEP_W'(ROOT_WIDTH);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == SQRT_STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[M2_WIDTH-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_WIDTH-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== test/wds_stats_checker.sv =====
// Scoreboard for welford_duration_statistics: keeps running count, mean, M2, min and max
// from every accepted duration and compares each result item field by field.
// Standalone; sees the block only through its ports.
module wds_stats_checker #(
	parameter int DURATION_WIDTH = 32,
	parameter int COUNT_WIDTH    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] duration,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] sample_count,
	input  logic [31:0] mean_value,
	input  logic        mean_valid,
	input  logic [31:0] std_dev,
	input  logic        std_dev_valid,
	input  logic [31:0] min_value,
	input  logic [31:0] max_value,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] count;
		logic [31:0] mean;
		logic        mean_ok;
		logic [31:0] sdev;
		logic        sdev_ok;
		logic [31:0] lo;
		logic [31:0] hi;
	} stats_t;

	localparam logic [63:0] DUR_MASK  = (64'd1 << DURATION_WIDTH) - 64'd1;
	localparam logic [63:0] COUNT_SAT = (64'd1 << COUNT_WIDTH) - 64'd1;

	logic [63:0] n_samples;
	logic [63:0] run_mean;
	logic [63:0] sq_sum;
	logic [63:0] run_min;
	logic [63:0] run_max;
	stats_t      expected_stats[$];
	stats_t      got;
	stats_t      want;
	int          errs;

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = 64'd0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	task automatic fold_duration(input logic [31:0] raw, output stats_t r);
		logic [63:0]  d;
		logic [63:0]  first_dev;
		logic [63:0]  second_dev;
		logic [63:0]  prior;
		logic [63:0]  term;
		logic [127:0] prod;
		logic [64:0]  acc;
		d = {32'd0, raw} & DUR_MASK;
		prior = n_samples;
		if (n_samples < COUNT_SAT)
			n_samples = n_samples + 64'd1;
		if (prior == 64'd0) begin
			run_mean = d;
			sq_sum   = 64'd0;
			run_min  = d;
			run_max  = d;
		end else begin
			if (d >= run_mean) begin
				first_dev  = d - run_mean;
				run_mean   = run_mean + first_dev / n_samples;
				second_dev = d - run_mean;
			end else begin
				first_dev  = run_mean - d;
				run_mean   = run_mean - first_dev / n_samples;
				second_dev = run_mean - d;
			end
			run_mean = run_mean & DUR_MASK;
			prod = {64'd0, first_dev} * {64'd0, second_dev};
			term = (prod[127:64] != 64'd0) ? {64{1'b1}} : prod[63:0];
			acc = {1'b0, sq_sum} + {1'b0, term};
			sq_sum = acc[64] ? {64{1'b1}} : acc[63:0];
			if (d < run_min)
				run_min = d;
			if (d > run_max)
				run_max = d;
		end
		r.count   = n_samples[31:0];
		r.mean_ok = (n_samples >= 64'd1);
		r.mean    = r.mean_ok ? run_mean[31:0] : 32'd0;
		r.sdev_ok = (n_samples >= 64'd2);
		r.sdev    = r.sdev_ok ? 32'(floor_sqrt(sq_sum / (n_samples - 64'd1))) : 32'd0;
		r.lo      = run_min[31:0];
		r.hi      = run_max[31:0];
	endtask

	function automatic int field_diff(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_samples = 64'd0;
			run_mean  = 64'd0;
			sq_sum    = 64'd0;
			run_min   = 64'd0;
			run_max   = 64'd0;
			expected_stats.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			errs = 0;
			if (out_valid && out_ready) begin
				got = '{count: sample_count, mean: mean_value, mean_ok: mean_valid,
					sdev: std_dev, sdev_ok: std_dev_valid, lo: min_value, hi: max_value};
				if (expected_stats.size() == 0) begin
					$display("%0t: unexpected result item, expected none actual count %h",
						$time, sample_count);
					errs = 1;
				end else begin
					want = expected_stats.pop_front();
					errs = field_diff("sample_count", want.count, got.count)
						+ field_diff("mean_value", want.mean, got.mean)
						+ field_diff("mean_valid", 32'(want.mean_ok), 32'(got.mean_ok))
						+ field_diff("std_dev", want.sdev, got.sdev)
						+ field_diff("std_dev_valid", 32'(want.sdev_ok), 32'(got.sdev_ok))
						+ field_diff("min_value", want.lo, got.lo)
						+ field_diff("max_value", want.hi, got.hi);
				end
			end
			if (in_valid && in_ready) begin
				fold_duration(duration, want);
				expected_stats.push_back(want);
			end
			fail_count <= fail_count + errs;
			pending    <= expected_stats.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Top of the welford_duration_statistics testbench: clock, reset, duration stimulus
// in directed and random phases with sender idling and receiver stalls, and the verdict.
// Depends on wds_pkg, welford_duration_statistics and wds_stats_checker.
module tb_top;

	localparam int CYCLE_LIMIT = 500_000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] duration;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] sample_count;
	logic [31:0] mean_value;
	logic        mean_valid;
	logic [31:0] std_dev;
	logic        std_dev_valid;
	logic [31:0] min_value;
	logic [31:0] max_value;
	int          fail_count;
	int          pending;
	int          stall_pct;
	int          cycles;

	logic [31:0] opening [12] = '{
		32'h0003_8000, 32'h0003_8000, 32'h0001_0000, 32'h000A_0000,
		32'h0000_0000, 32'h0000_0001, 32'h0000_0003, 32'h0005_5555,
		32'h0002_AAAB, 32'h0004_0000, 32'h0000_8000, 32'h000A_0000
	};
	logic [31:0] closing [7] = '{
		32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
		32'h7FFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF
	};

	welford_duration_statistics dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.duration(duration),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_count(sample_count),
		.mean_value(mean_value),
		.mean_valid(mean_valid),
		.std_dev(std_dev),
		.std_dev_valid(std_dev_valid),
		.min_value(min_value),
		.max_value(max_value)
	);

	wds_stats_checker stats_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.duration(duration),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_count(sample_count),
		.mean_value(mean_value),
		.mean_valid(mean_valid),
		.std_dev(std_dev),
		.std_dev_valid(std_dev_valid),
		.min_value(min_value),
		.max_value(max_value),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [31:0] pick_duration(input bit wide);
		int span;
		if (wide) begin
			case ($urandom_range(0, 5))
				0: return 32'hFFFF_FFFF;
				1: return 32'h0000_0000;
				2: return 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
				default: return $urandom;
			endcase
		end
		span = $urandom_range(1, 24);
		return $urandom & ((32'd1 << span) - 32'd1);
	endfunction

	task automatic send_duration(input logic [31:0] value, input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			duration <= $urandom;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		duration <= value;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// hold off the sender until every outstanding result item is back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int items, input int idle_pct, input int stall,
			input bit wide);
		@(posedge clk);
		stall_pct = stall;
		repeat (items) begin
			if ($urandom_range(0, 29) == 0)
				drain();
			send_duration(pick_duration(wide), idle_pct);
		end
		drain();
	endtask

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		duration  = 32'd0;
		stall_pct = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i])
			send_duration(opening[i], 0);
		drain();

		run_phase(90, 0, 0, 1'b0);
		run_phase(90, 58, 0, 1'b0);
		run_phase(90, 0, 58, 1'b0);

		@(posedge clk);
		stall_pct = 34;
		foreach (closing[i])
			send_duration(closing[i], 34);
		drain();

		run_phase(110, 34, 34, 1'b1);

		repeat (200) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
